@@ rtl/amrs_pkg.sv @@
`timescale 1ns / 1ps

package amrs_pkg;

    localparam int AMRS_NUM_MAILBOXES = 16;
    localparam int AMRS_POOL_SLOTS    = 256;

    localparam int MAILBOX_W   = 4;
    localparam int SENDER_W    = 16;
    localparam int PAYLOAD_W   = 32;
    localparam int REMAINING_W = 9;

    // stream word widths; the tdata widths are padded to whole bytes
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 64;
    localparam int S_TUSER_W = 2;
    localparam int M_TUSER_W = 2;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_TAKE  = 2'd1,
        OP_GET   = 2'd2,
        OP_FLUSH = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

endpackage

@@ rtl/actor_mailbox_ready_scheduler.sv @@
`timescale 1ns / 1ps

// Actor mailboxes over one shared message pool, with a FIFO of ready mailboxes.
// Each word on the s_ side is one command (put, take-ready, get, flush) and
// produces exactly one result word on the m_ side. One command is in flight at
// a time. Put, flush and any command that finds nothing to do go from accept
// to result through one synchronous read of the mailbox table, free-list link
// and ready FIFO, then the write-back; take-ready and a successful get add a
// second read that depends on the first (the popped mailbox's table entry, or
// the head message slot and its link). The result sits in an output register,
// so a new command is accepted while it waits; the block stalls only when a
// finished result cannot be placed. After reset the block initializes every
// pool link and mailbox table entry, one entry per cycle, with s_tready low.
module actor_mailbox_ready_scheduler #(
    parameter int NUM_MAILBOXES = amrs_pkg::AMRS_NUM_MAILBOXES,
    parameter int POOL_SLOTS    = amrs_pkg::AMRS_POOL_SLOTS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // mailbox[3:0], sender[19:4], payload[51:20], zero fill [55:52]
    input  logic [amrs_pkg::S_TDATA_W-1:0] s_tdata,
    // opcode[1:0]
    input  logic [amrs_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // ready_mailbox[3:0], msg_sender[19:4], msg_payload[51:20],
    // remaining[60:52], wake_worker[61], zero fill [63:62]
    output logic [amrs_pkg::M_TDATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [amrs_pkg::M_TUSER_W-1:0] m_tuser
);
    import amrs_pkg::*;

    localparam int BW    = $clog2(NUM_MAILBOXES);
    localparam int PW    = $clog2(POOL_SLOTS);
    localparam int CW    = $clog2(POOL_SLOTS + 1);
    localparam int RCW   = $clog2(NUM_MAILBOXES + 1);
    localparam int CLR_N = (POOL_SLOTS > NUM_MAILBOXES) ? POOL_SLOTS : NUM_MAILBOXES;
    localparam int CLW   = $clog2(CLR_N);

    typedef struct packed {
        logic          ready;
        logic [CW-1:0] count;
        logic [PW-1:0] last;
        logic [PW-1:0] first;
    } box_entry_t;

    typedef struct packed {
        logic [SENDER_W-1:0]  sender;
        logic [PAYLOAD_W-1:0] payload;
    } slot_entry_t;

    typedef enum logic [3:0] {
        S_CLR    = 4'b0001,
        S_IDLE   = 4'b0010,
        S_LOOK   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    // memories
    box_entry_t    box_ram  [NUM_MAILBOXES];
    slot_entry_t   slot_ram [POOL_SLOTS];
    logic [PW-1:0] link_ram [POOL_SLOTS];
    logic [BW-1:0] fifo_ram [NUM_MAILBOXES];

    box_entry_t    box_rd_reg;
    slot_entry_t   slot_rd_reg;
    logic [PW-1:0] link_rd_reg;
    logic [BW-1:0] fifo_rd_reg;

    logic          box_re, box_we, slot_re, slot_we, link_re, link_we, fifo_we;
    logic [BW-1:0] box_rd_addr, box_wr_addr, fifo_wr_addr;
    logic [PW-1:0] slot_rd_addr, slot_wr_addr, link_rd_addr, link_wr_addr, link_wr_data;
    box_entry_t    box_wr_data;
    slot_entry_t   slot_wr_data;
    logic [BW-1:0] fifo_wr_data;

    // control and command registers
    state_t                 state_reg, state_next;
    logic [CLW-1:0]         clr_reg, clr_next;
    opcode_t                op_reg, op_next;
    logic [BW-1:0]          box_reg, box_next;
    logic [SENDER_W-1:0]    sender_reg, sender_next;
    logic [PAYLOAD_W-1:0]   payload_reg, payload_next;
    logic [PW-1:0]          free_first_reg, free_first_next;
    logic [PW-1:0]          free_last_reg, free_last_next;
    logic [CW-1:0]          free_count_reg, free_count_next;
    logic [BW-1:0]          ready_rd_reg, ready_rd_next;
    logic [BW-1:0]          ready_wr_reg, ready_wr_next;
    logic [RCW-1:0]         ready_count_reg, ready_count_next;

    // result register
    logic                   m_valid_reg, m_valid_next;
    status_t                m_status_reg, m_status_next;
    logic [MAILBOX_W-1:0]   m_rbox_reg, m_rbox_next;
    logic [SENDER_W-1:0]    m_sender_reg, m_sender_next;
    logic [PAYLOAD_W-1:0]   m_payload_reg, m_payload_next;
    logic [REMAINING_W-1:0] m_rem_reg, m_rem_next;
    logic                   m_wake_reg, m_wake_next;

    logic          out_free, done, mark, room;
    logic [BW-1:0] ready_wr_inc, ready_rd_inc, in_box;
    logic [CW-1:0] count_dec;
    box_entry_t    ent;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = M_TUSER_W'(m_status_reg);
    assign m_tdata  = {2'b00, m_wake_reg, m_rem_reg, m_payload_reg, m_sender_reg, m_rbox_reg};

    assign ready_wr_inc = (ready_wr_reg == BW'(NUM_MAILBOXES - 1)) ? '0 : ready_wr_reg + 1'b1;
    assign ready_rd_inc = (ready_rd_reg == BW'(NUM_MAILBOXES - 1)) ? '0 : ready_rd_reg + 1'b1;
    assign room         = (ready_count_reg != RCW'(NUM_MAILBOXES));
    assign ent          = box_rd_reg;
    assign count_dec    = ent.count - 1'b1;

    // wrap the mailbox index through a constant lookup
    always_comb begin
        in_box = '0;
        for (int i = 0; i < 2 ** MAILBOX_W; i++) begin
            if (s_tdata[MAILBOX_W-1:0] == MAILBOX_W'(i)) begin
                in_box = BW'(i % NUM_MAILBOXES);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (box_we) begin
            box_ram[box_wr_addr] <= box_wr_data;
        end
        if (box_re) begin
            box_rd_reg <= box_ram[box_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_ram[slot_wr_addr] <= slot_wr_data;
        end
        if (slot_re) begin
            slot_rd_reg <= slot_ram[slot_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_ram[link_wr_addr] <= link_wr_data;
        end
        if (link_re) begin
            link_rd_reg <= link_ram[link_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (fifo_we) begin
            fifo_ram[fifo_wr_addr] <= fifo_wr_data;
        end
        if (state_reg == S_IDLE) begin
            fifo_rd_reg <= fifo_ram[ready_rd_reg];
        end
    end

    always_comb begin
        state_next       = state_reg;
        clr_next         = clr_reg;
        op_next          = op_reg;
        box_next         = box_reg;
        sender_next      = sender_reg;
        payload_next     = payload_reg;
        free_first_next  = free_first_reg;
        free_last_next   = free_last_reg;
        free_count_next  = free_count_reg;
        ready_rd_next    = ready_rd_reg;
        ready_wr_next    = ready_wr_reg;
        ready_count_next = ready_count_reg;

        m_status_next  = ST_DONE;
        m_rbox_next    = '0;
        m_sender_next  = '0;
        m_payload_next = '0;
        m_rem_next     = '0;
        m_wake_next    = 1'b0;
        done           = 1'b0;
        mark           = 1'b0;

        box_re       = 1'b0;
        box_rd_addr  = box_reg;
        box_we       = 1'b0;
        box_wr_addr  = box_reg;
        box_wr_data  = ent;
        slot_re      = 1'b0;
        slot_rd_addr = ent.first;
        slot_we      = 1'b0;
        slot_wr_addr = free_first_reg;
        slot_wr_data = '{sender: sender_reg, payload: payload_reg};
        link_re      = 1'b0;
        link_rd_addr = free_first_reg;
        link_we      = 1'b0;
        link_wr_addr = free_last_reg;
        link_wr_data = ent.first;
        fifo_we      = 1'b0;
        fifo_wr_addr = ready_wr_reg;
        fifo_wr_data = box_reg;

        case (state_reg)
            S_CLR: begin
                // chain the pool as a free list and empty every mailbox
                if (32'(clr_reg) < POOL_SLOTS) begin
                    link_we      = 1'b1;
                    link_wr_addr = clr_reg[PW-1:0];
                    link_wr_data = (32'(clr_reg) == POOL_SLOTS - 1) ? '0
                                                                    : clr_reg[PW-1:0] + 1'b1;
                end
                if (32'(clr_reg) < NUM_MAILBOXES) begin
                    box_we      = 1'b1;
                    box_wr_addr = clr_reg[BW-1:0];
                    box_wr_data = '0;
                end
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == CLR_N - 1) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next      = opcode_t'(s_tuser);
                    box_next     = in_box;
                    sender_next  = s_tdata[MAILBOX_W +: SENDER_W];
                    payload_next = s_tdata[MAILBOX_W + SENDER_W +: PAYLOAD_W];
                    box_re       = 1'b1;
                    box_rd_addr  = in_box;
                    link_re      = 1'b1;
                    link_rd_addr = free_first_reg;
                    state_next   = S_LOOK;
                end
            end
            S_LOOK: begin
                case (op_reg)
                    OP_PUT: begin
                        if (out_free) begin
                            done = 1'b1;
                            if (free_count_reg == '0) begin
                                m_status_next = ST_FULL;
                                m_rem_next    = REMAINING_W'(ent.count);
                            end else begin
                                mark            = !ent.ready && room;
                                slot_we         = 1'b1;
                                free_first_next = link_rd_reg;
                                free_count_next = free_count_reg - 1'b1;
                                // append behind the current tail
                                if (ent.count != '0) begin
                                    link_we      = 1'b1;
                                    link_wr_addr = ent.last;
                                    link_wr_data = free_first_reg;
                                end
                                box_we            = 1'b1;
                                box_wr_data.first = (ent.count == '0) ? free_first_reg
                                                                      : ent.first;
                                box_wr_data.last  = free_first_reg;
                                box_wr_data.count = ent.count + 1'b1;
                                box_wr_data.ready = ent.ready | mark;
                                m_rem_next        = REMAINING_W'(ent.count + 1'b1);
                            end
                        end
                    end
                    OP_TAKE: begin
                        if (ready_count_reg == '0) begin
                            if (out_free) begin
                                done          = 1'b1;
                                m_status_next = ST_EMPTY;
                            end
                        end else begin
                            box_re      = 1'b1;
                            box_rd_addr = fifo_rd_reg;
                            box_next    = fifo_rd_reg;
                            state_next  = S_FINISH;
                        end
                    end
                    OP_GET: begin
                        if (ent.count == '0) begin
                            if (out_free) begin
                                done          = 1'b1;
                                m_status_next = ST_EMPTY;
                            end
                        end else begin
                            slot_re      = 1'b1;
                            slot_rd_addr = ent.first;
                            link_re      = 1'b1;
                            link_rd_addr = ent.first;
                            state_next   = S_FINISH;
                        end
                    end
                    OP_FLUSH: begin
                        if (out_free) begin
                            done = 1'b1;
                            if (ent.count != '0) begin
                                // splice the whole chain onto the free list
                                if (free_count_reg == '0) begin
                                    free_first_next = ent.first;
                                end else begin
                                    link_we      = 1'b1;
                                    link_wr_addr = free_last_reg;
                                    link_wr_data = ent.first;
                                end
                                free_last_next    = ent.last;
                                free_count_next   = free_count_reg + ent.count;
                                box_we            = 1'b1;
                                box_wr_data.count = '0;
                            end
                        end
                    end
                    default: begin
                        done = out_free;
                    end
                endcase
            end
            S_FINISH: begin
                if (out_free) begin
                    done = 1'b1;
                    case (op_reg)
                        OP_TAKE: begin
                            ready_rd_next     = ready_rd_inc;
                            ready_count_next  = ready_count_reg - 1'b1;
                            box_we            = 1'b1;
                            box_wr_data.ready = 1'b0;
                            m_rbox_next       = MAILBOX_W'(box_reg);
                            m_rem_next        = REMAINING_W'(ent.count);
                        end
                        OP_GET: begin
                            mark           = (count_dec != '0) && !ent.ready && room;
                            m_sender_next  = slot_rd_reg.sender;
                            m_payload_next = slot_rd_reg.payload;
                            m_rem_next     = REMAINING_W'(count_dec);
                            // return the head slot to the free list
                            if (free_count_reg == '0) begin
                                free_first_next = ent.first;
                            end else begin
                                link_we      = 1'b1;
                                link_wr_addr = free_last_reg;
                                link_wr_data = ent.first;
                            end
                            free_last_next    = ent.first;
                            free_count_next   = free_count_reg + 1'b1;
                            box_we            = 1'b1;
                            box_wr_data.first = link_rd_reg;
                            box_wr_data.count = count_dec;
                            box_wr_data.ready = ent.ready | mark;
                        end
                        default: begin
                            m_status_next = ST_DONE;
                        end
                    endcase
                end
            end
            default: begin
                state_next = S_CLR;
            end
        endcase

        // append the mailbox to the ready FIFO
        if (mark) begin
            fifo_we          = 1'b1;
            ready_wr_next    = ready_wr_inc;
            ready_count_next = ready_count_reg + 1'b1;
            m_wake_next      = (ready_count_reg == '0);
        end

        if (done) begin
            state_next   = S_IDLE;
            m_valid_next = 1'b1;
        end else begin
            m_valid_next = m_valid_reg && !m_tready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_CLR;
            clr_reg         <= '0;
            free_first_reg  <= '0;
            free_last_reg   <= PW'(POOL_SLOTS - 1);
            free_count_reg  <= CW'(POOL_SLOTS);
            ready_rd_reg    <= '0;
            ready_wr_reg    <= '0;
            ready_count_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            clr_reg         <= clr_next;
            free_first_reg  <= free_first_next;
            free_last_reg   <= free_last_next;
            free_count_reg  <= free_count_next;
            ready_rd_reg    <= ready_rd_next;
            ready_wr_reg    <= ready_wr_next;
            ready_count_reg <= ready_count_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        box_reg     <= box_next;
        sender_reg  <= sender_next;
        payload_reg <= payload_next;
        if (done) begin
            m_status_reg  <= m_status_next;
            m_rbox_reg    <= m_rbox_next;
            m_sender_reg  <= m_sender_next;
            m_payload_reg <= m_payload_next;
            m_rem_reg     <= m_rem_next;
            m_wake_reg    <= m_wake_next;
        end
    end

endmodule
